### src/range_filter_aggregate_defines.svh
// Assertion macros shared by the range filter/aggregate RTL.
// Needs nothing else; included by the modules that assert.
`ifndef RANGE_FILTER_AGGREGATE_DEFINES_SVH
`define RANGE_FILTER_AGGREGATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rfa_pkg.sv
// Package for the range filter/aggregate block: widths, codes, sequencer states.
// No dependencies; imported by range_filter_aggregate, rfa_checker and the bench.
`default_nettype none

package rfa_pkg;

	localparam int LIST_DEPTH   = 16;
	localparam int COLLECT_KEYS = 32;
	localparam int LIST_AW      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int SCAN_W       = $clog2(LIST_DEPTH + 1);

	localparam int KEY_W      = 63;
	localparam int VAL_W      = 64;
	localparam int COUNT_W    = 32;
	localparam int S_TDATA_W  = 128;
	localparam int M_TDATA_W  = 224;
	localparam int M_TUSER_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 63;
	localparam int MODE_W     = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_STOP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_EXCLUSIVE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_INCLUSIVE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AGG_MODE        = 3'd4;

	// fold modes
	localparam logic [MODE_W-1:0] MODE_COLLECT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SUM     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MAX     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_AVG     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SET     = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STOP,
		ST_START,
		ST_FOLD,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

### src/range_filter_aggregate.sv
// Range filter and fold over a sorted key/value scan, one shared comparator.
// Depends on rfa_pkg and range_filter_aggregate_defines.svh.
//
// Channel  Dir  Handshake                   Payload
// s_axis   in   s_axis_tvalid/tready        tdata: key, value; tuser: restart; tlast: index end
// m_axis   out  m_axis_tvalid/tready        tdata: key, value, agg, count; tuser: flags;
//                                           tlast: done
// cfg      in   cfg_we (no stall)           cfg_index, cfg_data
//
// Steps from accept to result: stop check, start check, fold, finish; a beat past the stop
// or after done skips from stop check to finish, one below the start from start check.
// Set mode with list room adds a walk over the stored list (one read port, one comparator).
// Result sits in an output register; the next beat is accepted while it waits,
// and the sequencer holds in its finish step only if the old result is still there.
// Reset (arst_n low) clears sequencer, aggregate, count, done and config; the list
// itself is not cleared, entries are only compared below the fill count.
`default_nettype none

`include "range_filter_aggregate_defines.svh"

module range_filter_aggregate (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input beats
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [rfa_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [62:0] pair_key, [126:63] pair_value, [127] zero
	input  wire logic                            s_axis_tuser,  // [0] restart
	input  wire logic                            s_axis_tlast,  // index_end
	// result beats
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [rfa_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [62:0] out_key, [126:63] out_value,
	                                                            // [190:127] agg_result, [222:191] count, [223] zero
	output logic [rfa_pkg::M_TUSER_W-1:0]        m_axis_tuser,  // [0] taken, [1] list_full, [2] duplicate
	output logic                                 m_axis_tlast,  // done_res
	// configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [rfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import rfa_pkg::*;

	// configuration
	logic [KEY_W-1:0]   start_q;
	logic [KEY_W-1:0]   stop_q;
	logic               start_excl_q;
	logic               stop_incl_q;
	logic [MODE_W-1:0]  agg_mode_q;

	// query state
	logic [VAL_W-1:0]   agg_q;
	logic [COUNT_W-1:0] count_q;
	logic               done_q;

	// beat in flight
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic               last_q;
	logic               taken_q;
	logic               full_q;
	logic               dup_q;
	logic               echo_q;

	state_t state_q, state_d;

	// list walk
	logic [VAL_W-1:0]   list_mem [LIST_DEPTH];
	logic [VAL_W-1:0]   rd_s1;
	logic               rd_vld_s1;
	logic [SCAN_W-1:0]  scan_q;

	// result register
	logic               out_vld_q;
	logic [KEY_W-1:0]   out_key_q;
	logic [VAL_W-1:0]   out_value_q;
	logic [VAL_W-1:0]   out_agg_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [M_TUSER_W-1:0] out_flags_q;
	logic               out_done_q;

	// shared comparator
	logic [VAL_W-1:0]   cmp_a, cmp_b;
	logic               cmp_eq, cmp_gt;

	logic               accept;
	logic               past, above;
	logic               list_room, scan_more;
	logic               mem_we, mem_re, out_load;
	logic [COUNT_W-1:0] count_inc;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign list_room = count_q < COUNT_W'(LIST_DEPTH);
	// only used while count_q < LIST_DEPTH, so the low bits hold it
	assign scan_more = scan_q < count_q[SCAN_W-1:0];
	assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);

	// One magnitude comparator, operands picked by the sequencer step:
	// stop check key vs stop, start check key vs start, max fold value vs
	// aggregate, list walk stored entry vs value.
	always_comb begin
		cmp_a = {1'b0, key_q};
		cmp_b = {1'b0, stop_q};
		case (state_q)
			ST_STOP: begin
				cmp_a = {1'b0, key_q};
				cmp_b = {1'b0, stop_q};
			end
			ST_START: begin
				cmp_a = {1'b0, key_q};
				cmp_b = {1'b0, start_q};
			end
			ST_FOLD: begin
				cmp_a = val_q;
				cmp_b = agg_q;
			end
			ST_SCAN: begin
				cmp_a = rd_s1;
				cmp_b = val_q;
			end
			default: begin
				cmp_a = {1'b0, key_q};
				cmp_b = {1'b0, stop_q};
			end
		endcase
	end

	assign cmp_eq = cmp_a == cmp_b;
	assign cmp_gt = cmp_a > cmp_b;
	assign past   = cmp_gt || (cmp_eq && !stop_incl_q);
	assign above  = cmp_gt || (cmp_eq && !start_excl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_STOP;
			end
			ST_STOP: begin
				// a finished query ignores the beat
				state_d = (done_q || past) ? ST_FIN : ST_START;
			end
			ST_START: begin
				state_d = above ? ST_FOLD : ST_FIN;
			end
			ST_FOLD: begin
				mem_we  = (agg_mode_q == MODE_PUSH) && list_room;
				state_d = ((agg_mode_q == MODE_SET) && list_room) ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: begin
				mem_re = scan_more;
				// exit once the last read has been compared
				if (!scan_more && !rd_vld_s1) begin
					mem_we  = !dup_q;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_vld_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_axis_tready = state_q == ST_IDLE;

	// list storage: one write port (fill position), one registered read port (walk)
	always_ff @(posedge clk) begin
		if (mem_we) list_mem[count_q[LIST_AW-1:0]] <= val_q;
		if (mem_re) rd_s1 <= list_mem[scan_q[LIST_AW-1:0]];
	end

	// control and query state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			stop_q       <= '0;
			start_excl_q <= 1'b0;
			stop_incl_q  <= 1'b0;
			agg_mode_q   <= MODE_COLLECT;
			agg_q        <= '0;
			count_q      <= '0;
			done_q       <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RANGE_START:     start_q      <= cfg_data;
					CFG_RANGE_STOP:      stop_q       <= cfg_data;
					CFG_START_EXCLUSIVE: start_excl_q <= cfg_data[0];
					CFG_STOP_INCLUSIVE:  stop_incl_q  <= cfg_data[0];
					CFG_AGG_MODE:        agg_mode_q   <= cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end

			if (accept && s_axis_tuser) begin
				agg_q   <= '0;
				count_q <= '0;
				done_q  <= 1'b0;
			end

			case (state_q)
				ST_STOP: begin
					if (!done_q && past) done_q <= 1'b1;
				end
				ST_FOLD: begin
					case (agg_mode_q)
						MODE_COLLECT: begin
							if (count_q < COUNT_W'(COLLECT_KEYS)) count_q <= count_inc;
						end
						MODE_SUM: agg_q <= agg_q + val_q;
						MODE_MAX: begin
							if (cmp_gt) agg_q <= val_q;
						end
						MODE_AVG: begin
							agg_q   <= agg_q + val_q;
							count_q <= count_inc;
						end
						MODE_PUSH: begin
							if (list_room) count_q <= count_inc;
						end
						MODE_SET: rd_vld_s1 <= 1'b0;
						default: ;
					endcase
				end
				ST_SCAN: begin
					rd_vld_s1 <= mem_re;
					if (mem_we) count_q <= count_inc;
				end
				ST_FIN: begin
					if (out_load && last_q) done_q <= 1'b1;
				end
				default: ;
			endcase

			if (out_load) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

	// beat payload and flags
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= s_axis_tdata[KEY_W-1:0];
			val_q   <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
			last_q  <= s_axis_tlast;
			taken_q <= 1'b0;
			full_q  <= 1'b0;
			dup_q   <= 1'b0;
			echo_q  <= 1'b0;
		end

		case (state_q)
			ST_FOLD: begin
				scan_q <= '0;
				case (agg_mode_q)
					MODE_COLLECT: begin
						if (count_q < COUNT_W'(COLLECT_KEYS)) begin
							taken_q <= 1'b1;
							echo_q  <= 1'b1;
						end else begin
							full_q <= 1'b1;
						end
					end
					MODE_SUM, MODE_MAX, MODE_AVG: taken_q <= 1'b1;
					MODE_PUSH: begin
						if (list_room) taken_q <= 1'b1;
						else full_q <= 1'b1;
					end
					MODE_SET: begin
						if (!list_room) full_q <= 1'b1;
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (rd_vld_s1 && cmp_eq) dup_q <= 1'b1;
				if (mem_re) scan_q <= scan_q + SCAN_W'(1);
				if (mem_we) taken_q <= 1'b1;
			end
			default: ;
		endcase

		if (out_load) begin
			out_key_q   <= echo_q ? key_q : '0;
			out_value_q <= echo_q ? val_q : '0;
			out_agg_q   <= agg_q;
			out_count_q <= count_q;
			out_flags_q <= {dup_q, full_q, taken_q};
			out_done_q  <= done_q || last_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, out_count_q, out_agg_q, out_value_q, out_key_q};
	assign m_axis_tuser  = out_flags_q;
	assign m_axis_tlast  = out_done_q;

	`RFA_ASSERT_NOW(a_write_in_list, clk, arst_n, mem_we, count_q < COUNT_W'(LIST_DEPTH), "list write beyond depth")
	`RFA_ASSERT_NOW(a_scan_bound, clk, arst_n, state_q == ST_SCAN, scan_q <= count_q[SCAN_W-1:0], "list walk past fill count")
	`RFA_ASSERT_NOW(a_flags_excl, clk, arst_n, out_load, !(taken_q && (full_q || dup_q)), "taken together with a drop flag")
	`RFA_ASSERT_NEXT(a_restart_clears, clk, arst_n, accept && s_axis_tuser, (count_q == '0) && (agg_q == '0) && !done_q, "restart did not clear query state")

endmodule

`default_nettype wire

### test/rfa_checker.sv
// Checker for range_filter_aggregate: shadows config writes, predicts every result beat.
// Depends on rfa_pkg; instantiated by tb_range_filter_aggregate beside the block.
module rfa_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [rfa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            s_axis_tlast,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [rfa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input  logic [rfa_pkg::M_TUSER_W-1:0]   m_axis_tuser,
	input  logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [rfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rfa_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              err_count,
	output int                              pending,
	output int                              n_results,
	output int                              n_taken,
	output int                              n_full,
	output int                              n_dup
);
	timeunit 1ns;
	timeprecision 1ps;
	import rfa_pkg::*;

	typedef struct packed {
		logic               taken;
		logic               done;
		logic               full;
		logic               dup;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [VAL_W-1:0]   agg;
		logic [COUNT_W-1:0] count;
	} fold_result_t;

	// query settings as last written
	logic [KEY_W-1:0]   q_start, q_stop;
	logic               q_excl, q_incl;
	logic [MODE_W-1:0]  q_mode;
	// fold state
	logic [VAL_W-1:0]   agg_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [VAL_W-1:0]   stored [LIST_DEPTH];
	logic               done_q;

	fold_result_t folds_due[$];

	function automatic void bump_count();
		if (cnt_q != '1)
			cnt_q++;
	endfunction

	function automatic fold_result_t fold_pair(logic restart, logic [KEY_W-1:0] key,
		logic [VAL_W-1:0] val, logic last);
		fold_result_t r;
		logic past_stop, at_start;
		int i;
		r = '0;
		if (restart) begin
			agg_q  = '0;
			cnt_q  = '0;
			done_q = 1'b0;
		end
		if (!done_q) begin
			past_stop = (key > q_stop) || (key == q_stop && !q_incl);
			at_start  = q_excl ? (key > q_start) : (key >= q_start);
			if (past_stop) begin
				done_q = 1'b1;
			end else if (at_start) begin
				case (q_mode)
					MODE_COLLECT: begin
						if (cnt_q < COLLECT_KEYS) begin
							bump_count();
							r.taken = 1'b1;
							r.key   = key;
							r.value = val;
						end else begin
							r.full = 1'b1;
						end
					end
					MODE_SUM: begin
						agg_q   = agg_q + val;
						r.taken = 1'b1;
					end
					MODE_MAX: begin
						if (val > agg_q)
							agg_q = val;
						r.taken = 1'b1;
					end
					MODE_AVG: begin
						agg_q = agg_q + val;
						bump_count();
						r.taken = 1'b1;
					end
					MODE_PUSH: begin
						if (cnt_q < LIST_DEPTH) begin
							stored[cnt_q[LIST_AW-1:0]] = val;
							cnt_q++;
							r.taken = 1'b1;
						end else begin
							r.full = 1'b1;
						end
					end
					MODE_SET: begin
						if (cnt_q < LIST_DEPTH) begin
							for (i = 0; i < cnt_q; i++)
								if (stored[i] == val)
									r.dup = 1'b1;
							if (!r.dup) begin
								stored[cnt_q[LIST_AW-1:0]] = val;
								cnt_q++;
								r.taken = 1'b1;
							end
						end else begin
							r.full = 1'b1;
						end
					end
					default: ;  // spare modes fold nothing
				endcase
			end
			if (last)
				done_q = 1'b1;
		end
		r.done  = done_q;
		r.agg   = agg_q;
		r.count = cnt_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		fold_result_t got, want;
		string diffs;
		if (!arst_n) begin
			q_start   <= '0;
			q_stop    <= '0;
			q_excl    <= 1'b0;
			q_incl    <= 1'b0;
			q_mode    <= MODE_COLLECT;
			agg_q     = '0;
			cnt_q     = '0;
			done_q    = 1'b0;
			folds_due.delete();
			err_count = 0;
			pending   = 0;
			n_results = 0;
			n_taken   = 0;
			n_full    = 0;
			n_dup     = 0;
		end else begin
			// results first: a beat accepted at this edge is still far from its result
			if (m_axis_tvalid && m_axis_tready) begin
				got.key   = m_axis_tdata[62:0];
				got.value = m_axis_tdata[126:63];
				got.agg   = m_axis_tdata[190:127];
				got.count = m_axis_tdata[222:191];
				got.taken = m_axis_tuser[0];
				got.full  = m_axis_tuser[1];
				got.dup   = m_axis_tuser[2];
				got.done  = m_axis_tlast;
				n_results++;
				n_taken += got.taken;
				n_full  += got.full;
				n_dup   += got.dup;
				if (folds_due.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%t: result beat %0d with nothing outstanding: key=%h value=%h",
							$realtime, n_results, got.key, got.value);
				end else begin
					want  = folds_due.pop_front();
					diffs = "";
					if (want.taken !== got.taken) diffs = {diffs, " taken"};
					if (want.done  !== got.done)  diffs = {diffs, " done"};
					if (want.full  !== got.full)  diffs = {diffs, " list_full"};
					if (want.dup   !== got.dup)   diffs = {diffs, " duplicate"};
					if (want.key   !== got.key)   diffs = {diffs, " out_key"};
					if (want.value !== got.value) diffs = {diffs, " out_value"};
					if (want.agg   !== got.agg)   diffs = {diffs, " agg_result"};
					if (want.count !== got.count) diffs = {diffs, " count"};
					if (diffs != "") begin
						err_count++;
						if (err_count <= 10) begin
							$display("%t: result beat %0d differs in%s", $realtime, n_results, diffs);
							$display("  expected t=%b d=%b f=%b u=%b key=%h val=%h agg=%h cnt=%0d",
								want.taken, want.done, want.full, want.dup,
								want.key, want.value, want.agg, want.count);
							$display("  actual   t=%b d=%b f=%b u=%b key=%h val=%h agg=%h cnt=%0d",
								got.taken, got.done, got.full, got.dup,
								got.key, got.value, got.agg, got.count);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				folds_due.push_back(fold_pair(s_axis_tuser, s_axis_tdata[62:0],
					s_axis_tdata[126:63], s_axis_tlast));
			// register writes land at the same edge as in the block
			if (cfg_we) begin
				case (cfg_index)
					CFG_RANGE_START:     q_start <= cfg_data[KEY_W-1:0];
					CFG_RANGE_STOP:      q_stop  <= cfg_data[KEY_W-1:0];
					CFG_START_EXCLUSIVE: q_excl  <= cfg_data[0];
					CFG_STOP_INCLUSIVE:  q_incl  <= cfg_data[0];
					CFG_AGG_MODE:        q_mode  <= cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			pending = folds_due.size();
		end
	end

endmodule

### test/tb_range_filter_aggregate.sv
// Top of the range_filter_aggregate bench: clock, reset, query setups and scan beats.
// Depends on rfa_pkg, range_filter_aggregate and rfa_checker (prediction, compare).
module tb_range_filter_aggregate;
	timeunit 1ns;
	timeprecision 1ps;
	import rfa_pkg::*;

	localparam logic [KEY_W-1:0]  KEY_MAX = '1;
	localparam logic [VAL_W-1:0]  VAL_MAX = '1;
	// mode codes the block leaves unused
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
	localparam int RANDOM_PAIRS = 1400;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tready = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = CFG_RANGE_START;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	wire logic                 s_axis_tready;
	wire logic                 m_axis_tvalid;
	wire logic [M_TDATA_W-1:0] m_axis_tdata;
	wire logic [M_TUSER_W-1:0] m_axis_tuser;
	wire logic                 m_axis_tlast;

	int err_count, pending, n_results, n_taken, n_full, n_dup;

	// shadow of the query, used only to aim the keys and pick the values
	logic [KEY_W-1:0]  cur_start;
	logic [MODE_W-1:0] cur_mode;
	int                pairs_sent = 0;
	int                setups     = 0;
	int                burst_left = 0;

	always #2 clk = ~clk;

	range_filter_aggregate DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [62:0] pair_key, [126:63] pair_value, [127] zero
		.s_axis_tuser  (s_axis_tuser),   // [0] restart
		.s_axis_tlast  (s_axis_tlast),   // index_end
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [62:0] out_key, [126:63] out_value,
		                                 // [190:127] agg_result, [222:191] count, [223] zero
		.m_axis_tuser  (m_axis_tuser),   // [0] taken, [1] list_full, [2] duplicate
		.m_axis_tlast  (m_axis_tlast),   // done_res
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	rfa_checker fold_check (
		.clk (clk), .arst_n (arst_n),
		.s_axis_tvalid (s_axis_tvalid), .s_axis_tready (s_axis_tready),
		.s_axis_tdata (s_axis_tdata), .s_axis_tuser (s_axis_tuser), .s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid), .m_axis_tready (m_axis_tready),
		.m_axis_tdata (m_axis_tdata), .m_axis_tuser (m_axis_tuser), .m_axis_tlast (m_axis_tlast),
		.cfg_we (cfg_we), .cfg_index (cfg_index), .cfg_data (cfg_data),
		.err_count (err_count), .pending (pending), .n_results (n_results),
		.n_taken (n_taken), .n_full (n_full), .n_dup (n_dup)
	);

	// Result side backpressure: cycles through four moods in turn,
	// from always ready down to long stalls.
	always @(posedge clk) begin : rx_pattern
		int unsigned rx_cycle;
		int          rx_hold;
		rx_cycle++;
		case ((rx_cycle >> 8) % 4)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					m_axis_tready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					rx_hold = $urandom_range(10, 40);
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		endcase
	end

	function automatic logic [KEY_W-1:0] rand_key();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[KEY_W-1:0];
	endfunction

	// values: full random, a small pool (duplicates in set mode), the extremes
	function automatic logic [VAL_W-1:0] rand_value(input bit few);
		int pick;
		pick = $urandom_range(0, 9);
		if (few && pick < 6)
			return VAL_W'($urandom_range(0, 7));
		case (pick)
			0:       return '0;
			1:       return VAL_MAX;
			2:       return VAL_W'($urandom_range(0, 7));
			3:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Writes all five registers back to back. The one-bit and mode registers
	// sometimes carry junk above their width, which the block must ignore.
	task automatic set_query(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
		input logic excl, input logic incl, input logic [MODE_W-1:0] mode);
		logic [CFG_DATA_W-1:0] pad;
		pad = ($urandom_range(0, 2) == 0) ? rand_key() : '0;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_RANGE_START;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_RANGE_STOP;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= CFG_START_EXCLUSIVE;
		cfg_data  <= {pad[CFG_DATA_W-1:1], excl};
		@(posedge clk);
		cfg_index <= CFG_STOP_INCLUSIVE;
		cfg_data  <= {pad[CFG_DATA_W-1:1], incl};
		@(posedge clk);
		cfg_index <= CFG_AGG_MODE;
		cfg_data  <= {pad[CFG_DATA_W-1:MODE_W], mode};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_start = lo;
		cur_mode  = mode;
		setups++;
	endtask

	// One beat. Valid stays up through a burst; between bursts it drops for a gap.
	task automatic send_pair(input logic restart, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] val, input logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, val, key};
		s_axis_tuser  <= restart;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		pairs_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 15);
		end
	endtask

	// Hold off until every result is back, then idle with valid low.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	// Ascending scan that starts near the range start; repeated keys
	// allowed. Set mode relies on the first beat of a setup carrying restart,
	// so no list entry is compared before it was written.
	task automatic run_scan(input int len, input logic restart_first);
		logic [KEY_W-1:0] key;
		logic             mark_end;
		int               i, step;
		mark_end = 1'($urandom_range(0, 1));
		key = (cur_start > 8) ? cur_start - KEY_W'($urandom_range(0, 8))
			: KEY_W'($urandom_range(0, 3));
		for (i = 0; i < len; i++) begin
			send_pair(restart_first && i == 0, key, rand_value(cur_mode == MODE_SET),
				mark_end && i == len - 1);
			step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
			if (key <= KEY_MAX - KEY_W'(step))
				key = key + KEY_W'(step);
		end
	endtask

	task automatic random_setup();
		logic [KEY_W-1:0]  lo, hi;
		logic [MODE_W-1:0] mode;
		int                m, width, len;
		m    = $urandom_range(0, 12);
		mode = (m < 12) ? MODE_W'(m / 2) : (m[0] ? MODE_SPARE6 : MODE_SPARE7);
		case ($urandom_range(0, 5))
			0:       lo = '0;
			1:       lo = KEY_MAX - KEY_W'($urandom_range(0, 40));
			2:       lo = KEY_W'($urandom_range(0, 1000));
			default: lo = rand_key();
		endcase
		width = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 30);
		hi = (lo > KEY_MAX - KEY_W'(width)) ? KEY_MAX : lo + KEY_W'(width);
		if ($urandom_range(0, 9) == 0)
			hi = ($urandom_range(0, 1) == 0) ? KEY_MAX : rand_key();
		set_query(lo, hi, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), mode);
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 24);
		run_scan(len, 1'b1);
		repeat ($urandom_range(0, 3)) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 24);
			if ($urandom_range(0, 4) == 0) begin
				// noise: keys anywhere, stray restarts and index ends
				repeat ($urandom_range(1, 6))
					send_pair($urandom_range(0, 3) == 0,
						($urandom_range(0, 1) != 0) ? rand_key()
							: cur_start + KEY_W'($urandom_range(0, 40)),
						rand_value(1'b0), $urandom_range(0, 7) == 0);
			end else begin
				run_scan(len, $urandom_range(0, 2) != 0);
			end
		end
		drain();
	endtask

	initial begin : stimulus
		int directed;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur_start = '0;
		cur_mode  = MODE_COLLECT;

		// reset query: stop 0 exclusive, so key 0 already ends it; later beats fold nothing
		send_pair(1'b0, '0, VAL_MAX, 1'b0);
		send_pair(1'b0, 63'd5, 64'd1, 1'b0);
		send_pair(1'b1, '0, '0, 1'b1);
		drain();
		// exclusive start at the top key: nothing can pass
		set_query(KEY_MAX, KEY_MAX, 1'b1, 1'b1, MODE_SUM);
		send_pair(1'b1, KEY_MAX, VAL_MAX, 1'b0);
		send_pair(1'b0, '0, 64'd1, 1'b0);
		drain();
		// full key range, max fold, index end then a beat after done
		set_query('0, KEY_MAX, 1'b0, 1'b1, MODE_MAX);
		send_pair(1'b1, '0, 64'd5, 1'b0);
		send_pair(1'b0, 63'd1, VAL_MAX, 1'b0);
		send_pair(1'b0, KEY_MAX, 64'd3, 1'b1);
		send_pair(1'b0, 63'd2, 64'd7, 1'b0);
		drain();
		// sum wraps; top key hits an exclusive stop
		set_query('0, KEY_MAX, 1'b0, 1'b0, MODE_SUM);
		send_pair(1'b1, '0, VAL_MAX, 1'b0);
		send_pair(1'b0, 63'd1, 64'd2, 1'b0);
		send_pair(1'b0, KEY_MAX, 64'd1, 1'b0);
		drain();
		set_query(63'd10, 63'd20, 1'b1, 1'b0, MODE_AVG);
		send_pair(1'b1, 63'd10, 64'd4, 1'b0);
		send_pair(1'b0, 63'd11, 64'd6, 1'b0);
		send_pair(1'b0, 63'd20, 64'd1, 1'b0);
		drain();
		set_query('0, 63'd100, 1'b0, 1'b1, MODE_PUSH);
		send_pair(1'b1, 63'd3, 64'd9, 1'b0);
		send_pair(1'b0, 63'd4, 64'd9, 1'b0);
		drain();
		// set: duplicate, a zero value, duplicate on the stop key with index end
		set_query('0, 63'd100, 1'b0, 1'b1, MODE_SET);
		send_pair(1'b1, 63'd5, 64'd9, 1'b0);
		send_pair(1'b0, 63'd6, 64'd9, 1'b0);
		send_pair(1'b0, 63'd7, '0, 1'b0);
		send_pair(1'b0, 63'd100, '0, 1'b1);
		drain();
		set_query('0, 63'd100, 1'b0, 1'b1, MODE_SPARE6);
		send_pair(1'b1, 63'd1, 64'd1, 1'b0);
		drain();
		set_query('0, 63'd100, 1'b0, 1'b1, MODE_SPARE7);
		send_pair(1'b1, 63'd1, 64'd1, 1'b0);
		drain();

		directed = pairs_sent;
		while (pairs_sent < directed + RANDOM_PAIRS)
			random_setup();

		drain();
		repeat (30) @(posedge clk);
		$display("%0d pairs over %0d query setups, all six fold modes and both spare codes;",
			pairs_sent, setups);
		$display("%0d results: %0d folded, %0d dropped on a full list, %0d duplicates",
			n_results, n_taken, n_full, n_dup);
		if (err_count == 0 && pending == 0) begin
			$display("tb_range_filter_aggregate: done, clean");
		end else begin
			$display("tb_range_filter_aggregate: done, errors");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("tb_range_filter_aggregate: done, errors");
		$finish;
	end

endmodule
